### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/rcsg_pkg.sv
`default_nettype none

package rcsg_pkg;

    localparam int unsigned RATE_W  = 27;
    localparam int unsigned IDX_W   = 17;
    localparam int unsigned SHIFT_W = 9;
    localparam int unsigned LFSR_W  = 9;

    localparam logic [RATE_W-1:0]  CHIP_RATE   = RATE_W'(511000);
    localparam logic [RATE_W-1:0]  RATE_MIN    = RATE_W'(511000);
    localparam logic [RATE_W-1:0]  RATE_MAX    = RATE_W'(100000000);
    localparam logic [RATE_W-1:0]  SAMPLE_STEP = RATE_W'(1000);
    localparam logic [SHIFT_W-1:0] CODE_LEN    = SHIFT_W'(511);
    localparam logic [LFSR_W-1:0]  LFSR_ONES   = '1;

    typedef enum logic [0:0] {
        REG_SAMPLE_RATE = 1'b0,
        REG_CODE_SHIFT  = 1'b1
    } reg_index_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // latch config, reseed shift register, clear counters
        logic step;   // advance shift register one chip during seek
        logic emit;   // produce the current sample and, unless it is the last, advance
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic seek_zero;
        logic last;
        logic out_free;
    } dp_status_t;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] r);
        logic fb;
        fb = r[4] ^ r[0];
        return {fb, r[LFSR_W-1:1]};
    endfunction

endpackage

`default_nettype wire

### rtl/rcsg_ctrl.sv
`default_nettype none

module rcsg_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                restart,
    input  wire rcsg_pkg::dp_status_t status,
    output logic                     s_tready,
    output rcsg_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_SEEK = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   pending_reg, pending_next;
    logic   primed_reg, primed_next;
    logic   need_start;

    assign need_start = (restart || pending_reg) && !primed_reg;
    assign s_tready   = (state_reg == ST_RUN) && status.out_free && !need_start;

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        primed_next  = primed_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (s_tvalid && need_start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEEK;
                end
                else if (s_tvalid && s_tready)
                begin
                    cmd.emit     = 1'b1;
                    primed_next  = 1'b0;
                    pending_next = status.last;
                end
            end
            ST_SEEK:
            begin
                if (status.seek_zero)
                begin
                    primed_next = 1'b1;
                    state_next  = ST_RUN;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            pending_reg <= 1'b1;
            primed_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            primed_reg  <= primed_next;
        end
    end

endmodule

`default_nettype wire

### rtl/rcsg_datapath.sv
`default_nettype none

module rcsg_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [rcsg_pkg::RATE_W-1:0]  cfg_data,
    input  wire rcsg_pkg::ctrl_cmd_t          cmd,
    input  wire logic                         m_tready,
    output rcsg_pkg::dp_status_t              status,
    output logic                              m_tvalid,
    output logic                              out_chip,
    output logic [rcsg_pkg::IDX_W-1:0]        out_index,
    output logic                              out_last
);

    localparam int unsigned RW = rcsg_pkg::RATE_W;
    localparam int unsigned IW = rcsg_pkg::IDX_W;
    localparam int unsigned SW = rcsg_pkg::SHIFT_W;
    localparam int unsigned LW = rcsg_pkg::LFSR_W;

    logic [RW-1:0] cfg_rate_reg;
    logic [SW-1:0] cfg_shift_reg;
    logic          out_valid_reg;

    logic [RW-1:0] run_rate_reg;
    logic [LW-1:0] lfsr_reg;
    logic [SW-1:0] seek_cnt_reg;
    logic [IW-1:0] count_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] limit_reg;    // (count + 2) * 1000
    logic          chip_reg;
    logic [IW-1:0] index_reg;
    logic          last_reg;

    logic [RW-1:0] rate_sat;
    logic [SW-1:0] shift_mod;
    logic [RW:0]   rem_sum;
    logic          chip_adv;
    logic          last;

    always_comb
    begin
        if (cfg_rate_reg < rcsg_pkg::RATE_MIN)
            rate_sat = rcsg_pkg::RATE_MIN;
        else if (cfg_rate_reg > rcsg_pkg::RATE_MAX)
            rate_sat = rcsg_pkg::RATE_MAX;
        else
            rate_sat = cfg_rate_reg;
    end

    assign shift_mod = (cfg_shift_reg == rcsg_pkg::CODE_LEN) ? '0 : cfg_shift_reg;
    assign rem_sum   = {1'b0, rem_reg} + {1'b0, rcsg_pkg::CHIP_RATE};
    assign chip_adv  = rem_sum >= {1'b0, run_rate_reg};
    // Last sample when (count + 2) * 1000 exceeds the rate.
    assign last      = limit_reg > run_rate_reg;

    assign status.seek_zero = (seek_cnt_reg == '0);
    assign status.last      = last;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign out_chip  = chip_reg;
    assign out_index = index_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_rate_reg  <= rcsg_pkg::RATE_MIN;
            cfg_shift_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == rcsg_pkg::REG_SAMPLE_RATE)
                    cfg_rate_reg <= cfg_data;
                else
                    cfg_shift_reg <= cfg_data[SW-1:0];
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            run_rate_reg <= rate_sat;
            lfsr_reg     <= rcsg_pkg::LFSR_ONES;
            seek_cnt_reg <= shift_mod;
            count_reg    <= '0;
            rem_reg      <= rcsg_pkg::CHIP_RATE - RW'(1);
            limit_reg    <= rcsg_pkg::SAMPLE_STEP + rcsg_pkg::SAMPLE_STEP;
        end
        else if (cmd.step)
        begin
            lfsr_reg     <= rcsg_pkg::lfsr_next(lfsr_reg);
            seek_cnt_reg <= seek_cnt_reg - SW'(1);
        end
        else if (cmd.emit)
        begin
            chip_reg  <= lfsr_reg[2];
            index_reg <= count_reg;
            last_reg  <= last;
            if (!last)
            begin
                count_reg <= count_reg + IW'(1);
                limit_reg <= limit_reg + rcsg_pkg::SAMPLE_STEP;
                if (chip_adv)
                begin
                    rem_reg  <= RW'(rem_sum - {1'b0, run_rate_reg});
                    lfsr_reg <= rcsg_pkg::lfsr_next(lfsr_reg);
                end
                else
                begin
                    rem_reg <= rem_sum[RW-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ranging_code_sample_generator.sv
`default_nettype none

`include "assert_macros.svh"

// Sampled 511-chip ranging code generator. Each input beat yields one output
// beat holding the code value at that sample, its index in the code period
// and a last flag; a period has floor(rate / 1000) samples. Inside a period
// the block takes one beat per clock while the output is free. A period start
// (first beat after reset, a beat with restart set, or the beat after a last
// sample) first loads the settings and reseeks the shift register one chip per
// clock; the beat is taken once the seek count reaches zero. Rate and shift
// writes take effect at the next period start.
module ranging_code_sample_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [26:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // [0] chip_positive, [17:1] sample_index
    output logic             m_tlast     // last_of_code
);

    rcsg_pkg::ctrl_cmd_t  cmd;
    rcsg_pkg::dp_status_t status;
    logic                 out_chip;
    logic [rcsg_pkg::IDX_W-1:0] out_index;

    rcsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .restart  (s_tdata[0]),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    rcsg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .m_tready  (m_tready),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .out_chip  (out_chip),
        .out_index (out_index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'b0, out_index, out_chip};

    `ASSERT_NXT(a_load_blocks_input, clk, rst_n, cmd.load, !s_tready)
    `ASSERT_IMP(a_seek_no_input, clk, rst_n, cmd.step, !s_tready && !cmd.emit)
    `ASSERT_NXT(a_last_flagged, clk, rst_n, cmd.emit && status.last, m_tvalid && m_tlast)

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import rcsg_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER  = 900;
    localparam int unsigned ITEM_TARGET = 1750;

    typedef struct packed {
        logic        chip;
        logic [16:0] index;
        logic        last;
    } code_sample_t;

    class chip_sample_scoreboard;
        logic [26:0]  rate_setting;
        logic [8:0]   shift_setting;
        logic [8:0]   lfsr;
        int unsigned  sample_count;
        int unsigned  chip_phase;
        int unsigned  period_rate;
        int unsigned  period_len;
        bit           period_due;
        int unsigned  errors;
        code_sample_t expected_samples[$];

        function new();
            rate_setting  = RATE_MIN;
            shift_setting = '0;
            lfsr          = LFSR_ONES;
            sample_count  = 0;
            chip_phase    = 0;
            period_rate   = RATE_MIN;
            period_len    = RATE_MIN / SAMPLE_STEP;
            period_due    = 1'b1;
            errors        = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [26:0] data);
            if (idx == REG_SAMPLE_RATE)
                rate_setting = data;
            else
                shift_setting = data[8:0];
        endfunction

        // Latch the settings, clamp the rate and seek the code to the shifted start.
        function void begin_period();
            int unsigned seek;
            period_rate = rate_setting;
            if (period_rate < RATE_MIN)
                period_rate = RATE_MIN;
            if (period_rate > RATE_MAX)
                period_rate = RATE_MAX;
            period_len = period_rate / SAMPLE_STEP;
            seek = shift_setting % CODE_LEN;
            lfsr = LFSR_ONES;
            for (int k = 0; k < seek; k++)
                lfsr = {lfsr[4] ^ lfsr[0], lfsr[8:1]};
            sample_count = 0;
            chip_phase   = CHIP_RATE - 1;
            period_due   = 1'b0;
        endfunction

        function void note_input(logic restart);
            code_sample_t s;
            if (restart || period_due)
                begin_period();
            s.chip  = lfsr[2];
            s.index = 17'(sample_count);
            s.last  = (sample_count + 1 >= period_len);
            expected_samples.push_back(s);
            if (s.last)
                period_due = 1'b1;
            else
            begin
                sample_count++;
                chip_phase += CHIP_RATE;
                // at most one chip step per sample since rate >= chip rate
                if (chip_phase >= period_rate)
                begin
                    chip_phase -= period_rate;
                    lfsr = {lfsr[4] ^ lfsr[0], lfsr[8:1]};
                end
            end
        endfunction

        function void check_result(logic chip, logic [16:0] index, logic last);
            code_sample_t want;
            if (expected_samples.size() == 0)
            begin
                errors++;
                $display("%0t: sample with none expected: chip %0b index %0d last %0b",
                         $time, chip, index, last);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (chip !== want.chip)
                begin
                    errors++;
                    $display("%0t: chip_positive expected %0b, got %0b (index %0d)",
                             $time, want.chip, chip, want.index);
                end
                if (index !== want.index)
                begin
                    errors++;
                    $display("%0t: sample_index expected %0d, got %0d",
                             $time, want.index, index);
                end
                if (last !== want.last)
                begin
                    errors++;
                    $display("%0t: last_of_code expected %0b, got %0b (index %0d)",
                             $time, want.last, last, want.index);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_samples.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [26:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [0] chip_positive, [17:1] sample_index
    logic        m_tlast;

    chip_sample_scoreboard sb;
    bit          gaps_on;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned quiet_cycles;

    ranging_code_sample_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input logic restart);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(restart);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop the input and wait until every expected sample is out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cfg(input reg_index_t idx, input logic [26:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    initial
    begin : result_sink
        int unsigned stall;
        bit          held;
        logic        got_chip;
        logic [16:0] got_index;
        logic        got_last;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 6) : 0;
            // long hold-off while the sender keeps offering, to back up the block
            if (!held && results_seen >= HOLD_AFTER && s_tvalid)
            begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got_chip  = m_tdata[0];
            got_index = m_tdata[17:1];
            got_last  = m_tlast;
            @(negedge clk);
            sb.check_result(got_chip, got_index, got_last);
            results_seen++;
        end
    end

    initial
    begin : stimulus
        int unsigned len;
        int unsigned pick;
        logic [26:0] rate;
        logic        first_restart;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_SAMPLE_RATE;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        gaps_on      = 1'b1;
        items_sent   = 0;
        results_seen = 0;
        quiet_cycles = 0;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first beat after reset opens a period on its own
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        settle();

        // rate below minimum, shift of 511 wraps to zero; both wait for the next start
        write_cfg(REG_SAMPLE_RATE, 27'd0);
        write_cfg(REG_CODE_SHIFT, 27'd511);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        settle();

        // rate above maximum, largest legal shift
        write_cfg(REG_SAMPLE_RATE, '1);
        write_cfg(REG_CODE_SHIFT, 27'd510);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        settle();

        write_cfg(REG_SAMPLE_RATE, RATE_MAX);
        write_cfg(REG_CODE_SHIFT, 27'd1);
        send_item(1'b1);
        send_item(1'b0);
        settle();

        write_cfg(REG_SAMPLE_RATE, 27'd1022000);
        write_cfg(REG_CODE_SHIFT, 27'd0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b0);

        while (items_sent < ITEM_TARGET)
        begin
            settle();
            pick = $urandom_range(0, 5);
            if (pick == 0)
                rate = 27'($urandom);
            else if (pick == 1)
                rate = RATE_MIN + 27'($urandom_range(0, 2000000));
            else
                rate = RATE_MIN + 27'($urandom_range(0, 60000));
            if (pick != 1 || $urandom_range(0, 1) == 0)
                write_cfg(REG_SAMPLE_RATE, rate);
            if ($urandom_range(0, 2) != 0)
                write_cfg(REG_CODE_SHIFT, {18'($urandom), 9'($urandom_range(0, 511))});
            gaps_on = ($urandom_range(0, 3) != 0);
            if (pick == 0)
            begin
                len = $urandom_range(10, 40);
                first_restart = 1'b1;
            end
            else if (pick == 1)
            begin
                // continue the running period; the new settings wait for the next period start
                len = $urandom_range(20, 150);
                first_restart = 1'b0;
            end
            else
            begin
                // a whole period from restart through the wrap
                len = rate / SAMPLE_STEP + $urandom_range(0, 40);
                first_restart = 1'b1;
            end
            // stop at the item budget
            if (len > ITEM_TARGET - items_sent)
                len = ITEM_TARGET - items_sent;
            for (int i = 0; i < len; i++)
                send_item((i == 0 && first_restart) ||
                          (pick == 1 && $urandom_range(0, 99) == 0));
        end

        settle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/rcsg_pkg.sv
rtl/rcsg_ctrl.sv
rtl/rcsg_datapath.sv
rtl/ranging_code_sample_generator.sv
verif/tb_top.sv
